// ----- rtl/dpsm_pkg.sv -----
// package: drive power state codes, command codes and status word encoding
`timescale 1ns / 1ps

package dpsm_pkg;

  localparam int unsigned StateW = 3;
  localparam int unsigned AlW    = 8;
  localparam int unsigned CwW    = 16;
  localparam int unsigned ModeW  = 8;
  localparam int unsigned StatW  = 16;

  localparam logic [StateW-1:0] ST_DISABLED = 3'd0;
  localparam logic [StateW-1:0] ST_READY    = 3'd1;
  localparam logic [StateW-1:0] ST_SWITCHED = 3'd2;
  localparam logic [StateW-1:0] ST_ENABLED  = 3'd3;
  localparam logic [StateW-1:0] ST_QSTOP    = 3'd4;
  localparam logic [StateW-1:0] ST_FAULT    = 3'd5;

  localparam logic [4:0] AL_MASK   = 5'h1F;
  localparam logic [4:0] AL_SAFEOP = 5'h04;
  localparam logic [4:0] AL_OP     = 5'h08;

  localparam logic [CwW-1:0] CMD_MASK      = 16'h008F;
  localparam logic [CwW-1:0] CMD_DISABLE   = 16'h0000;
  localparam logic [CwW-1:0] CMD_SHUTDOWN  = 16'h0006;
  localparam logic [CwW-1:0] CMD_SWITCH_ON = 16'h0007;
  localparam logic [CwW-1:0] CMD_ENABLE_OP = 16'h000F;
  localparam logic [CwW-1:0] CMD_QSTOP     = 16'h0002;

  localparam int unsigned BIT_VOLTAGE = 1;
  localparam int unsigned BIT_QSTOP   = 2;
  localparam int unsigned BIT_FRESET  = 7;

  localparam logic [StatW-1:0] REMOTE_BIT = 16'h0200;

  localparam logic [StatW-1:0] CODE_DISABLED = 16'h0040;
  localparam logic [StatW-1:0] CODE_READY    = 16'h0021;
  localparam logic [StatW-1:0] CODE_SWITCHED = 16'h0023;
  localparam logic [StatW-1:0] CODE_ENABLED  = 16'h0027;
  localparam logic [StatW-1:0] CODE_QSTOP    = 16'h0007;
  localparam logic [StatW-1:0] CODE_FAULT    = 16'h0008;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic [StatW-1:0]  status;
  } step_t;

  function automatic logic [StatW-1:0] status_of(input logic [StateW-1:0] s);
    logic [StatW-1:0] code;
    unique case (s)
      ST_READY:    code = CODE_READY;
      ST_SWITCHED: code = CODE_SWITCHED;
      ST_ENABLED:  code = CODE_ENABLED;
      ST_QSTOP:    code = CODE_QSTOP;
      ST_FAULT:    code = CODE_FAULT;
      default:     code = CODE_DISABLED;
    endcase
    return code | REMOTE_BIT;
  endfunction

endpackage

// ----- rtl/dpsm_step.sv -----
// next drive state and status word from current state and one request
`timescale 1ns / 1ps

module dpsm_step (
  input  logic [dpsm_pkg::StateW-1:0] state_i,
  input  logic [dpsm_pkg::AlW-1:0]    al_state_i,
  input  logic [dpsm_pkg::CwW-1:0]    control_word_i,
  output dpsm_pkg::step_t             step_o
);

  function automatic logic [dpsm_pkg::StateW-1:0] transition(
    input logic [dpsm_pkg::StateW-1:0] s,
    input logic [dpsm_pkg::CwW-1:0]    cw
  );
    logic [dpsm_pkg::CwW-1:0]    cmd;
    logic [dpsm_pkg::StateW-1:0] ns;
    cmd = cw & dpsm_pkg::CMD_MASK;
    ns  = s;
    unique case (s)
      dpsm_pkg::ST_READY: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) ns = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SWITCH_ON) ns = dpsm_pkg::ST_SWITCHED;
      end
      dpsm_pkg::ST_SWITCHED: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) ns = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SHUTDOWN) ns = dpsm_pkg::ST_READY;
        else if (cmd == dpsm_pkg::CMD_ENABLE_OP) ns = dpsm_pkg::ST_ENABLED;
      end
      dpsm_pkg::ST_ENABLED: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) ns = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SHUTDOWN) ns = dpsm_pkg::ST_READY;
        else if (cmd == dpsm_pkg::CMD_SWITCH_ON) ns = dpsm_pkg::ST_SWITCHED;
        else if (cmd == dpsm_pkg::CMD_QSTOP || !cw[dpsm_pkg::BIT_QSTOP]) begin
          ns = dpsm_pkg::ST_QSTOP;
        end
      end
      dpsm_pkg::ST_QSTOP: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) ns = dpsm_pkg::ST_DISABLED;
        else if (cw[dpsm_pkg::BIT_QSTOP]) begin
          if (cmd == dpsm_pkg::CMD_ENABLE_OP) ns = dpsm_pkg::ST_ENABLED;
          else if (cmd == dpsm_pkg::CMD_SWITCH_ON) ns = dpsm_pkg::ST_SWITCHED;
          else if (cmd == dpsm_pkg::CMD_SHUTDOWN) ns = dpsm_pkg::ST_READY;
        end
      end
      dpsm_pkg::ST_FAULT: ns = s;
      default: begin
        if (cmd == dpsm_pkg::CMD_SHUTDOWN) ns = dpsm_pkg::ST_READY;
        else ns = dpsm_pkg::ST_DISABLED;
      end
    endcase
    return ns;
  endfunction

  logic [4:0]                  al;
  logic [dpsm_pkg::StateW-1:0] cur;
  logic [dpsm_pkg::StateW-1:0] nxt;

  assign al = al_state_i[4:0] & dpsm_pkg::AL_MASK;

  always_comb begin
    cur = state_i;
    nxt = dpsm_pkg::ST_DISABLED;
    if (al == dpsm_pkg::AL_SAFEOP || al == dpsm_pkg::AL_OP) begin
      // fault reset
      if (control_word_i[dpsm_pkg::BIT_FRESET] && cur == dpsm_pkg::ST_FAULT) begin
        cur = dpsm_pkg::ST_DISABLED;
      end
      nxt = transition(cur, control_word_i);
      if (!control_word_i[dpsm_pkg::BIT_VOLTAGE] && nxt != dpsm_pkg::ST_FAULT) begin
        nxt = dpsm_pkg::ST_DISABLED;
      end
      // safe-op caps at switched on
      if (al == dpsm_pkg::AL_SAFEOP && nxt == dpsm_pkg::ST_ENABLED) begin
        nxt = dpsm_pkg::ST_SWITCHED;
      end
    end
  end

  assign step_o.state  = nxt;
  assign step_o.status = dpsm_pkg::status_of(nxt);

endmodule

// ----- rtl/drive_power_state_machine.sv -----
// top level: drive power state machine with input and result registers
// Takes one request per clock cycle when the result side keeps up. A request
// is held in the input register, then the next-state logic on the
// three-bit drive state register produces its status word into the result
// register, so a result passes both registers before it is offered. The state
// register and the result register load together, which lets the following
// request see the updated state in the very next cycle. A stalled result
// holds the input register full; up to two requests are in flight.
`timescale 1ns / 1ps

module drive_power_state_machine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [dpsm_pkg::AlW-1:0]    al_state_i,
  input  logic        [dpsm_pkg::CwW-1:0]    control_word_i,
  input  logic signed [dpsm_pkg::ModeW-1:0]  mode_request_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [dpsm_pkg::StatW-1:0]  drive_status_o,
  output logic signed [dpsm_pkg::ModeW-1:0]  mode_echo_o
);

  logic                               in_valid_q;
  logic        [dpsm_pkg::AlW-1:0]    al_q;
  logic        [dpsm_pkg::CwW-1:0]    cw_q;
  logic signed [dpsm_pkg::ModeW-1:0]  mode_q;

  logic        [dpsm_pkg::StateW-1:0] state_q;
  logic        [dpsm_pkg::StateW-1:0] state_d;

  logic                               out_valid_q;
  logic        [dpsm_pkg::StatW-1:0]  status_q;
  logic signed [dpsm_pkg::ModeW-1:0]  mode_out_q;

  logic            advance;
  logic            in_take;
  dpsm_pkg::step_t step;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  dpsm_step u_step (
    .state_i        (state_q),
    .al_state_i     (al_q),
    .control_word_i (cw_q),
    .step_o         (step)
  );

  assign state_d = advance ? step.state : state_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      al_q   <= al_state_i;
      cw_q   <= control_word_i;
      mode_q <= mode_request_i;
    end
  end

  // drive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpsm_pkg::ST_DISABLED;
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= step.status;
      mode_out_q <= mode_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_status_o = status_q;
  assign mode_echo_o    = mode_out_q;

  a_status_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q == dpsm_pkg::status_of(state_q))
    else $error("status word does not match drive state");

  a_state_holds_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("drive state changed without a request");

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request produced no result");

  a_no_fault_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != dpsm_pkg::ST_FAULT)
    else $error("fault state entered");

  a_stall_keeps_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(cw_q) && $stable(al_q))
    else $error("pending request lost while result stalled");

endmodule

// ----- tb/tb_drive_power_state_machine.sv -----
// testbench: drive power state machine checked against its own state predictor
`timescale 1ns / 1ps

module tb_drive_power_state_machine;

  localparam int unsigned IdleLimit = 1000;

  typedef struct {
    logic        [dpsm_pkg::StatW-1:0] status;
    logic signed [dpsm_pkg::ModeW-1:0] mode;
  } drive_result_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic        [dpsm_pkg::AlW-1:0]    al_state_i;
  logic        [dpsm_pkg::CwW-1:0]    control_word_i;
  logic signed [dpsm_pkg::ModeW-1:0]  mode_request_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic        [dpsm_pkg::StatW-1:0]  drive_status_o;
  logic signed [dpsm_pkg::ModeW-1:0]  mode_echo_o;

  drive_result_t               pending_results[$];
  drive_result_t               oldest;
  logic [dpsm_pkg::StateW-1:0] drive_st;
  logic [7:0]                  states_seen;
  int                          errors;
  int                          requests_sent;
  int                          results_checked;
  int                          idle_cycles;
  int                          in_gap_max;
  int                          out_stall_max;

  drive_power_state_machine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .al_state_i     (al_state_i),
    .control_word_i (control_word_i),
    .mode_request_i (mode_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_status_o (drive_status_o),
    .mode_echo_o    (mode_echo_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [dpsm_pkg::StateW-1:0] next_drive_state(
    input logic [dpsm_pkg::StateW-1:0] cur,
    input logic [dpsm_pkg::AlW-1:0]    al,
    input logic [dpsm_pkg::CwW-1:0]    cw
  );
    logic [4:0]                  al_sel;
    logic [dpsm_pkg::CwW-1:0]    cmd;
    logic [dpsm_pkg::StateW-1:0] s;
    al_sel = al[4:0] & dpsm_pkg::AL_MASK;
    cmd    = cw & dpsm_pkg::CMD_MASK;
    s      = cur;
    if (al_sel != dpsm_pkg::AL_SAFEOP && al_sel != dpsm_pkg::AL_OP) begin
      return dpsm_pkg::ST_DISABLED;
    end
    if (cw[dpsm_pkg::BIT_FRESET] && s == dpsm_pkg::ST_FAULT) begin
      s = dpsm_pkg::ST_DISABLED;
    end
    case (s)
      dpsm_pkg::ST_READY: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) s = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SWITCH_ON) s = dpsm_pkg::ST_SWITCHED;
      end
      dpsm_pkg::ST_SWITCHED: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) s = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SHUTDOWN) s = dpsm_pkg::ST_READY;
        else if (cmd == dpsm_pkg::CMD_ENABLE_OP) s = dpsm_pkg::ST_ENABLED;
      end
      dpsm_pkg::ST_ENABLED: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) s = dpsm_pkg::ST_DISABLED;
        else if (cmd == dpsm_pkg::CMD_SHUTDOWN) s = dpsm_pkg::ST_READY;
        else if (cmd == dpsm_pkg::CMD_SWITCH_ON) s = dpsm_pkg::ST_SWITCHED;
        else if (cmd == dpsm_pkg::CMD_QSTOP || !cw[dpsm_pkg::BIT_QSTOP]) begin
          s = dpsm_pkg::ST_QSTOP;
        end
      end
      dpsm_pkg::ST_QSTOP: begin
        if (cmd == dpsm_pkg::CMD_DISABLE) s = dpsm_pkg::ST_DISABLED;
        else if (cw[dpsm_pkg::BIT_QSTOP]) begin
          if (cmd == dpsm_pkg::CMD_ENABLE_OP) s = dpsm_pkg::ST_ENABLED;
          else if (cmd == dpsm_pkg::CMD_SWITCH_ON) s = dpsm_pkg::ST_SWITCHED;
          else if (cmd == dpsm_pkg::CMD_SHUTDOWN) s = dpsm_pkg::ST_READY;
        end
      end
      dpsm_pkg::ST_FAULT: begin
      end
      default: begin
        s = (cmd == dpsm_pkg::CMD_SHUTDOWN) ? dpsm_pkg::ST_READY : dpsm_pkg::ST_DISABLED;
      end
    endcase
    if (!cw[dpsm_pkg::BIT_VOLTAGE] && s != dpsm_pkg::ST_FAULT) begin
      s = dpsm_pkg::ST_DISABLED;
    end
    if (al_sel == dpsm_pkg::AL_SAFEOP && s == dpsm_pkg::ST_ENABLED) begin
      s = dpsm_pkg::ST_SWITCHED;
    end
    return s;
  endfunction

  function automatic logic [dpsm_pkg::StatW-1:0] expected_status(
    input logic [dpsm_pkg::StateW-1:0] s
  );
    logic [dpsm_pkg::StatW-1:0] code;
    case (s)
      dpsm_pkg::ST_READY:    code = dpsm_pkg::CODE_READY;
      dpsm_pkg::ST_SWITCHED: code = dpsm_pkg::CODE_SWITCHED;
      dpsm_pkg::ST_ENABLED:  code = dpsm_pkg::CODE_ENABLED;
      dpsm_pkg::ST_QSTOP:    code = dpsm_pkg::CODE_QSTOP;
      dpsm_pkg::ST_FAULT:    code = dpsm_pkg::CODE_FAULT;
      default:               code = dpsm_pkg::CODE_DISABLED;
    endcase
    return dpsm_pkg::REMOTE_BIT | code;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [dpsm_pkg::StatW-1:0] got,
                                 input logic [dpsm_pkg::StatW-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_request(input logic [dpsm_pkg::AlW-1:0] al,
                              input logic [dpsm_pkg::CwW-1:0] cw,
                              input logic signed [dpsm_pkg::ModeW-1:0] mode);
    int            gap;
    drive_result_t res;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    al_state_i     <= al;
    control_word_i <= cw;
    mode_request_i <= mode;
    do @(posedge clk_i); while (!in_ready_o);
    drive_st    = next_drive_state(drive_st, al, cw);
    states_seen[drive_st] = 1'b1;
    res.status  = expected_status(drive_st);
    res.mode    = mode;
    pending_results.push_back(res);
    requests_sent++;
  endtask

  // drop valid in the acceptance step, then wait for every result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [dpsm_pkg::CwW-1:0] random_word(
    input logic [dpsm_pkg::CwW-1:0] cmd
  );
    logic [dpsm_pkg::CwW-1:0] w;
    w = {8'($urandom_range(255, 0)), 1'b0, 3'($urandom_range(7, 0)), 4'h0};
    if ($urandom_range(9, 0) == 0) w[dpsm_pkg::BIT_FRESET] = 1'b1;
    return w | cmd;
  endfunction

  function automatic logic [dpsm_pkg::AlW-1:0] random_al(input logic [4:0] sel);
    return {3'($urandom_range(7, 0)), sel};
  endfunction

  function automatic logic signed [dpsm_pkg::ModeW-1:0] random_mode();
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic test_al_forcing();
    send_request(8'h00, 16'hFFFF, 8'sh80);
    send_request(8'h08, 16'h0006, 8'sd127);
    send_request(8'h14, 16'h0006, 8'sd0);
    send_request(8'hE8, 16'h0006, -8'sd1);
    send_request(8'hE8, 16'hFF07, 8'sd5);
    send_request(8'hFF, 16'h0007, 8'sd6);
  endtask

  task automatic test_op_transitions();
    send_request(8'h08, 16'h0006, 8'sd1);
    send_request(8'h08, 16'h0003, 8'sd2);
    send_request(8'h08, 16'h0007, 8'sd3);
    send_request(8'h08, 16'h000F, 8'sd4);
    send_request(8'h08, 16'hFFFF, 8'sd5);
    send_request(8'h08, 16'h0007, 8'sd6);
    send_request(8'h08, 16'h0006, 8'sd7);
    send_request(8'h08, 16'h0000, 8'sd8);
  endtask

  task automatic test_quick_stop();
    send_request(8'h08, 16'h0006, 8'sd9);
    send_request(8'h08, 16'h0007, 8'sd10);
    send_request(8'h08, 16'h000F, 8'sd11);
    send_request(8'h08, 16'h0002, 8'sd12);
    send_request(8'h08, 16'h000B, 8'sd13);
    send_request(8'h08, 16'h000F, 8'sd14);
    send_request(8'h08, 16'h000B, 8'sd15);
    send_request(8'h08, 16'h0006, 8'sd16);
  endtask

  task automatic test_safeop_cap();
    send_request(8'h04, 16'h0007, 8'sd17);
    send_request(8'h04, 16'h000F, 8'sd18);
    send_request(8'h04, 16'h0086, 8'sd19);
    send_request(8'h04, 16'h0001, 8'sd20);
  endtask

  // random command runs, about half of them led by a well-formed power-up chain
  task automatic test_random_sequences(input int n_items);
    logic [dpsm_pkg::CwW-1:0] cmds[7];
    logic [4:0]               sel;
    int                       sent;
    int                       len;
    int                       pick;
    cmds = '{dpsm_pkg::CMD_DISABLE, dpsm_pkg::CMD_SHUTDOWN, dpsm_pkg::CMD_SWITCH_ON,
             dpsm_pkg::CMD_ENABLE_OP, dpsm_pkg::CMD_QSTOP, 16'h000B, 16'h0003};
    sent = 0;
    while (sent < n_items) begin
      if (sent % 100 == 0) begin
        pick          = $urandom_range(2, 0);
        in_gap_max    = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;
        out_stall_max = ($urandom_range(2, 0) == 0) ? 0 : 15;
      end
      if (sent > 0 && sent % 300 == 0) begin
        drain_results();
      end
      sel = ($urandom_range(3, 0) == 0) ? dpsm_pkg::AL_SAFEOP : dpsm_pkg::AL_OP;
      if ($urandom_range(1, 0) == 0) begin
        send_request(random_al(sel), random_word(dpsm_pkg::CMD_SHUTDOWN), random_mode());
        send_request(random_al(sel), random_word(dpsm_pkg::CMD_SWITCH_ON), random_mode());
        send_request(random_al(sel), random_word(dpsm_pkg::CMD_ENABLE_OP), random_mode());
        sent += 3;
      end
      len = $urandom_range(6, 2);
      repeat (len) begin
        if ($urandom_range(15, 0) == 0) begin
          sel = 5'($urandom_range(31, 0));
        end else if ($urandom_range(7, 0) == 0) begin
          sel = (sel == dpsm_pkg::AL_OP) ? dpsm_pkg::AL_SAFEOP : dpsm_pkg::AL_OP;
        end
        pick = $urandom_range(7, 0);
        if (pick < 7) begin
          send_request(random_al(sel), random_word(cmds[pick]), random_mode());
        end else begin
          send_request(random_al(sel), 16'($urandom_range(65535, 0)), random_mode());
        end
        sent++;
      end
    end
  endtask

  task automatic test_random_noise(input int n_items);
    in_gap_max    = 15;
    out_stall_max = 15;
    repeat (n_items) begin
      send_request(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)),
                   random_mode());
    end
  endtask

  task automatic test_drain_pause();
    in_gap_max    = 0;
    out_stall_max = 15;
    send_request(8'h08, 16'h0006, 8'sd21);
    send_request(8'h08, 16'h0007, 8'sd22);
    drain_results();
    send_request(8'h08, 16'h000F, 8'sd23);
    send_request(8'h04, 16'h000F, 8'sd24);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no pending request", drive_status_o, 16'h0000);
      end else begin
        oldest = pending_results.pop_front();
        if (drive_status_o !== oldest.status) begin
          report_mismatch("drive status", drive_status_o, oldest.status);
        end
        if (mode_echo_o !== oldest.mode) begin
          report_mismatch("mode echo", 16'(mode_echo_o), 16'(oldest.mode));
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("tb_drive_power_state_machine failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    al_state_i      <= '0;
    control_word_i  <= '0;
    mode_request_i  <= '0;
    drive_st        = dpsm_pkg::ST_DISABLED;
    states_seen     = '0;
    errors          = 0;
    requests_sent   = 0;
    results_checked = 0;
    idle_cycles     = 0;
    in_gap_max      = 0;
    out_stall_max   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_al_forcing();
    test_op_transitions();
    in_gap_max    = 15;
    out_stall_max = 15;
    test_quick_stop();
    test_safeop_cap();
    test_drain_pause();
    test_random_sequences(1300);
    test_random_noise(300);

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked", requests_sent, results_checked);
    $display("drive states reached, one bit per state code: %b", states_seen);
    if (errors == 0) begin
      $display("tb_drive_power_state_machine passed");
    end else begin
      $display("tb_drive_power_state_machine failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dpsm_pkg.sv
rtl/dpsm_step.sv
rtl/drive_power_state_machine.sv
tb/tb_drive_power_state_machine.sv
